### src/protobuf_envelope_parser_core_assert.svh
// Assertion macros for the protobuf envelope parser.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef PROTOBUF_ENVELOPE_PARSER_CORE_ASSERT_SVH
`define PROTOBUF_ENVELOPE_PARSER_CORE_ASSERT_SVH

// Check on an explicit clock, muted while the active-low reset is asserted.
`define PEP_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check on the block's own clock and reset.
`define PEP_ASSERT(lbl, prop, msg) \
  `PEP_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### src/pep_pkg.sv
// Shared types and constants of the protobuf envelope parser.
// No dependencies; used by the parser, result queue, top level and testbench.
package pep_pkg;

  // result kind codes
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // wire type codes that the parser accepts
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  localparam logic [3:0]  VarintLastIdx = 4'd9;   // tenth byte of a varint
  localparam logic [31:0] PayFieldLo    = 32'd10;
  localparam logic [31:0] PayFieldHi    = 32'd19;
  localparam logic [31:0] FieldVersion  = 32'd1;
  localparam logic [31:0] FieldReqId    = 32'd2;
  localparam int unsigned Fixed64Bytes  = 8;
  localparam int unsigned Fixed32Bytes  = 4;

  // result queue: depth and fill level up to which a new byte is taken
  localparam int unsigned ResDepth   = 8;
  localparam int unsigned MaxPerItem = 2;
  localparam int unsigned ResCntW    = $clog2(ResDepth + 1);
  localparam int unsigned ResPtrW    = $clog2(ResDepth);
  localparam int unsigned ResRoom    = ResDepth - 2 * MaxPerItem;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        status;
    logic [31:0] version;
    logic [63:0] req_ident;
    logic [4:0]  pay_field;
  } pep_result_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic [1:0]  count;
    pep_result_t res0;
    pep_result_t res1;
  } pep_push_t;

  // seven data bits of varint byte number cnt, placed at their weight
  function automatic logic [63:0] varint_part(logic [3:0] cnt, logic [6:0] bits);
    logic [63:0] part;
    case (cnt)
      4'd0:    part = {57'd0, bits};
      4'd1:    part = {50'd0, bits, 7'd0};
      4'd2:    part = {43'd0, bits, 14'd0};
      4'd3:    part = {36'd0, bits, 21'd0};
      4'd4:    part = {29'd0, bits, 28'd0};
      4'd5:    part = {22'd0, bits, 35'd0};
      4'd6:    part = {15'd0, bits, 42'd0};
      4'd7:    part = {8'd0, bits, 49'd0};
      4'd8:    part = {1'd0, bits, 56'd0};
      4'd9:    part = {bits[0], 63'd0};
      default: part = '0;
    endcase
    return part;
  endfunction

endpackage

### src/pep_if.sv
// Valid/ready stream interfaces for the envelope parser's byte input and result output.
// No dependencies.
interface pep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pep_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        status;
  logic [31:0] version;
  logic [63:0] req_ident;
  logic [4:0]  pay_field;

  modport source (output valid, output kind, output payload_byte, output status,
                  output version, output req_ident, output pay_field, input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input version, input req_ident, input pay_field, output ready);
endinterface

### src/pep_parser.sv
// Wire-format FSM: decodes one registered byte per step_i cycle, emits results.
// Depends on pep_pkg.
module pep_parser
  import pep_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = 1048576
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pep_push_t  push_o
);

  localparam int unsigned RemW = $clog2(MAX_MESSAGE_BYTES + 1);

  typedef enum logic [4:0] {
    MODE_TAG     = 5'b00001,
    MODE_VARVAL  = 5'b00010,
    MODE_LEN     = 5'b00100,
    MODE_PAYLOAD = 5'b01000,
    MODE_SKIP    = 5'b10000
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [63:0]      acc_q, acc_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [4:0]       fnum_q, fnum_d;     // low bits of current field number
  logic             f1_q, f1_d;         // current field is the version
  logic             f2_q, f2_d;         // current field is the request id
  logic             pay_q, pay_d;       // current field is a payload field
  logic [RemW-1:0]  rem_q, rem_d;
  logic [31:0]      ver_q, ver_d;
  logic [63:0]      rid_q, rid_d;
  logic [4:0]       pfield_q, pfield_d;
  logic             failed_q, failed_d;

  always_comb begin
    logic [63:0] v;
    logic [31:0] field;
    logic [2:0]  wtype;
    logic        tag_pay;
    logic        bad;
    pep_result_t summ;

    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    fnum_d   = fnum_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    pay_d    = pay_q;
    rem_d    = rem_q;
    ver_d    = ver_q;
    rid_d    = rid_q;
    pfield_d = pfield_q;
    failed_d = failed_q;
    push_o   = '0;
    bad      = 1'b0;
    summ     = '0;

    v       = acc_q | varint_part(cnt_q, byte_i[6:0]);
    field   = v[34:3];
    wtype   = v[2:0];
    tag_pay = (field inside {[PayFieldLo:PayFieldHi]}) && (wtype == WIRE_LEN);

    if (step_i) begin
      if (!failed_q) begin
        case (mode_q)
          MODE_PAYLOAD, MODE_SKIP: begin
            if (mode_q == MODE_PAYLOAD) begin
              push_o.count             = 2'd1;
              push_o.res0.kind         = KIND_PAYLOAD;
              push_o.res0.payload_byte = byte_i;
            end
            if (rem_q != '0) rem_d = rem_q - 1'b1;
            if (rem_q <= RemW'(1)) mode_d = MODE_TAG;
          end
          default: begin
            acc_d = v;
            if (!byte_i[7]) begin
              acc_d = '0;
              cnt_d = '0;
              if (mode_q == MODE_TAG) begin
                if (v == '0) begin
                  failed_d = 1'b1;
                end else begin
                  fnum_d = field[4:0];
                  f1_d   = (field == FieldVersion);
                  f2_d   = (field == FieldReqId);
                  pay_d  = tag_pay;
                  if (tag_pay && pfield_q != '0) begin
                    failed_d = 1'b1;
                  end else begin
                    case (wtype)
                      WIRE_VARINT: mode_d = MODE_VARVAL;
                      WIRE_LEN:    mode_d = MODE_LEN;
                      WIRE_I64: begin
                        mode_d = MODE_SKIP;
                        rem_d  = RemW'(Fixed64Bytes);
                      end
                      WIRE_I32: begin
                        mode_d = MODE_SKIP;
                        rem_d  = RemW'(Fixed32Bytes);
                      end
                      default: failed_d = 1'b1;
                    endcase
                  end
                end
              end else if (mode_q == MODE_VARVAL) begin
                if (f1_q) ver_d = v[31:0];
                else if (f2_q) rid_d = v;
                mode_d = MODE_TAG;
              end else begin
                if (v > 64'(MAX_MESSAGE_BYTES)) begin
                  failed_d = 1'b1;
                end else begin
                  if (pay_q) pfield_d = fnum_q;
                  if (v == '0) begin
                    mode_d = MODE_TAG;
                  end else begin
                    rem_d  = v[RemW-1:0];
                    mode_d = pay_q ? MODE_PAYLOAD : MODE_SKIP;
                  end
                end
              end
            end else if (cnt_q == VarintLastIdx) begin
              failed_d = 1'b1;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        endcase
      end

      if (last_i) begin
        bad            = failed_d || (mode_d != MODE_TAG) || (cnt_d != '0) || (pfield_d == '0);
        summ.kind      = KIND_SUMMARY;
        summ.status    = bad;
        summ.version   = bad ? '0 : ver_d;
        summ.req_ident = bad ? '0 : rid_d;
        summ.pay_field = bad ? '0 : pfield_d;
        if (push_o.count == 2'd1) begin
          push_o.res1  = summ;
          push_o.count = 2'd2;
        end else begin
          push_o.res0  = summ;
          push_o.count = 2'd1;
        end
        // message closed: back to the post-reset state
        mode_d   = MODE_TAG;
        acc_d    = '0;
        cnt_d    = '0;
        fnum_d   = '0;
        f1_d     = 1'b0;
        f2_d     = 1'b0;
        pay_d    = 1'b0;
        rem_d    = '0;
        ver_d    = '0;
        rid_d    = '0;
        pfield_d = '0;
        failed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TAG;
      acc_q    <= '0;
      cnt_q    <= '0;
      fnum_q   <= '0;
      f1_q     <= 1'b0;
      f2_q     <= 1'b0;
      pay_q    <= 1'b0;
      rem_q    <= '0;
      ver_q    <= '0;
      rid_q    <= '0;
      pfield_q <= '0;
      failed_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      fnum_q   <= fnum_d;
      f1_q     <= f1_d;
      f2_q     <= f2_d;
      pay_q    <= pay_d;
      rem_q    <= rem_d;
      ver_q    <= ver_d;
      rid_q    <= rid_d;
      pfield_q <= pfield_d;
      failed_q <= failed_d;
    end
  end

endmodule

### src/pep_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on pep_pkg.
module pep_result_fifo
  import pep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pep_push_t          push_i,
  input  logic               pop_i,
  output pep_result_t        head_o,
  output logic               valid_o,
  output logic [ResCntW-1:0] count_o
);

  pep_result_t        mem_q [ResDepth];
  logic [ResPtrW-1:0] wp_q, wp_d, wp_nxt;
  logic [ResPtrW-1:0] rp_q, rp_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;

  assign wp_nxt  = wp_q + 1'b1;
  assign head_o  = mem_q[rp_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  always_comb begin
    wp_d  = wp_q + ResPtrW'(push_i.count);
    rp_d  = (pop_i && valid_o) ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + ResCntW'(push_i.count) - ResCntW'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wp_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wp_nxt] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/protobuf_envelope_parser_core.sv
// Streaming protobuf envelope parser. Takes one encoded byte per transaction on in_i (with
// last_byte on the message's final byte) and sustains one byte per clock while out_o is not
// stalled. Each byte is held in an input register and decoded by the wire-format state
// machine, and its results (a payload byte, the end-of-message summary, or both) land in an
// 8-entry result queue that drives out_o. in_i.ready stays high while the queue holds at most
// four results; it only drops when out_o is stalled. A summary reports status 0 with version,
// request id and payload field number when the message was well formed and carried a payload,
// otherwise status 1 with zeros. After a malformed element the remaining bytes up to the last
// one are dropped.
// Depends on pep_pkg, pep_if, pep_parser, pep_result_fifo and the assertion macro header.
`include "protobuf_envelope_parser_core_assert.svh"

module protobuf_envelope_parser_core
  import pep_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = 1048576
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pep_in_if.sink    in_i,
  pep_out_if.source out_o
);

  // input register stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_take;
  logic       s1_end;      // a last byte is being decoded

  pep_push_t          push;
  pep_result_t        head;
  logic               head_valid;
  logic [ResCntW-1:0] fifo_count;

  // room for the byte in the register stage plus the new one
  assign in_i.ready = (fifo_count <= ResCntW'(ResRoom));
  assign in_take    = in_i.valid && in_i.ready;
  assign s1_end     = s1_valid_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  pep_parser #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_valid_q),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .push_o (push)
  );

  pep_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_count)
  );

  assign out_o.valid        = head_valid;
  assign out_o.kind         = head.kind;
  assign out_o.payload_byte = head.payload_byte;
  assign out_o.status       = head.status;
  assign out_o.version      = head.version;
  assign out_o.req_ident    = head.req_ident;
  assign out_o.pay_field    = head.pay_field;

  // a last byte always queues a summary
  `PEP_ASSERT(a_last_pushes_summary, s1_end |=> fifo_count != '0, "no summary after last byte")
  // no decoded byte, no new results
  `PEP_ASSERT(a_idle_hold, !s1_valid_q |=> fifo_count <= $past(fifo_count), "grew while idle")
  // the ready threshold keeps the queue from overflowing
  `PEP_ASSERT(a_no_overflow, fifo_count <= ResCntW'(ResDepth), "result queue overflow")

endmodule

### verif/testbench.sv
// Self-checking testbench for protobuf_envelope_parser_core: byte stream in, results out.
// Needs pep_pkg, the pep_in_if/pep_out_if interfaces and the core; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pep_pkg::*;

  // Must match the parameter handed to the core below.
  localparam int unsigned MaxMsgBytes   = 1048576;
  localparam int unsigned ItemsPerPhase = 175;   // random bytes per idling phase
  localparam int unsigned QuietLimit    = 5000;  // cycles with no transaction at all
  localparam int unsigned TailCycles    = 20;    // settle time after the last result

  // Wire types the parser must reject.
  localparam logic [2:0] WIRE_SGROUP = 3'd3;
  localparam logic [2:0] WIRE_EGROUP = 3'd4;
  localparam logic [2:0] WIRE_RSVD6  = 3'd6;
  localparam logic [2:0] WIRE_RSVD7  = 3'd7;

  localparam logic [7:0] VarintMore = 8'h80;  // continuation bit of a varint byte

  // What every malformed (or payload-less) message reports.
  localparam pep_result_t BadSummary = '{kind: KIND_SUMMARY, payload_byte: 8'h00,
                                         status: 1'b1, version: 32'h0,
                                         req_ident: 64'h0, pay_field: 5'h0};

  typedef enum logic [2:0] {PM_TAG, PM_VARVAL, PM_LEN, PM_PAYLOAD, PM_SKIP} parse_mode_e;

  // How a random message gets damaged, if at all.
  typedef enum {FLT_NONE, FLT_ZERO_TAG, FLT_BAD_WIRE, FLT_OVERLONG, FLT_SECOND_PAY,
                FLT_HUGE_LEN, FLT_TRUNCATE, FLT_NOISE} fault_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;   // 1: the row carries its own expected result
    pep_result_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  pep_in_if  in_if ();
  pep_out_if out_if ();

  protobuf_envelope_parser_core #(
    .MAX_MESSAGE_BYTES(MaxMsgBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: same state as the core, advanced once per accepted byte.
  // ---------------------------------------------------------------------------
  parse_mode_e pm;
  logic [63:0] acc;            // varint being assembled
  logic [3:0]  vcnt;           // bytes of it seen so far
  logic [31:0] cur_field;
  logic [2:0]  cur_wire;
  logic [20:0] remain;         // bytes left to skip or emit
  logic [31:0] kept_version;
  logic [63:0] kept_req_id;
  logic [4:0]  kept_pay_field;
  logic        malformed;

  pep_result_t step_results[$];      // what the latest byte produced
  pep_result_t awaited_results[$];   // everything still owed by the core

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  logic [7:0] msg_q[$];              // bytes of the message being built

  function automatic void clear_parser();
    pm             = PM_TAG;
    acc            = '0;
    vcnt           = '0;
    cur_field      = '0;
    cur_wire       = '0;
    remain         = '0;
    kept_version   = '0;
    kept_req_id    = '0;
    kept_pay_field = '0;
    malformed      = 1'b0;
  endfunction

  function automatic logic payload_tag();
    return (cur_field inside {[PayFieldLo:PayFieldHi]}) && cur_wire == WIRE_LEN;
  endfunction

  // A varint just ended; what it means depends on where we are in the element.
  function automatic void close_varint(input logic [63:0] v);
    case (pm)
      PM_TAG: begin
        if (v == '0) begin
          malformed = 1'b1;
        end else begin
          cur_field = v[34:3];
          cur_wire  = v[2:0];
          if (payload_tag() && kept_pay_field != '0) begin
            malformed = 1'b1;   // only one payload per message
          end else if (cur_wire == WIRE_VARINT) begin
            pm = PM_VARVAL;
          end else if (cur_wire == WIRE_LEN) begin
            pm = PM_LEN;
          end else if (cur_wire == WIRE_I64) begin
            pm     = PM_SKIP;
            remain = 21'(Fixed64Bytes);
          end else if (cur_wire == WIRE_I32) begin
            pm     = PM_SKIP;
            remain = 21'(Fixed32Bytes);
          end else begin
            malformed = 1'b1;
          end
        end
      end
      PM_VARVAL: begin
        if (cur_field == FieldVersion) kept_version = v[31:0];
        else if (cur_field == FieldReqId) kept_req_id = v;
        pm = PM_TAG;
      end
      default: begin   // length of a length-delimited field
        if (v > MaxMsgBytes) begin
          malformed = 1'b1;
        end else begin
          if (payload_tag()) kept_pay_field = cur_field[4:0];
          if (v == '0) begin
            pm = PM_TAG;
          end else begin
            remain = v[20:0];
            pm     = payload_tag() ? PM_PAYLOAD : PM_SKIP;
          end
        end
      end
    endcase
  endfunction

  // Results that one accepted byte causes, left in step_results.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic [63:0] v;
    pep_result_t r;
    step_results.delete();
    if (!malformed) begin
      if (pm == PM_PAYLOAD || pm == PM_SKIP) begin
        if (pm == PM_PAYLOAD) begin
          r              = '0;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          step_results   = {step_results, r};
        end
        if (remain != '0) remain = remain - 1'b1;
        if (remain == '0) pm = PM_TAG;
      end else begin
        acc = acc | ({57'd0, b[6:0]} << (7 * vcnt));
        if (!b[7]) begin
          v    = acc;
          acc  = '0;
          vcnt = '0;
          close_varint(v);
        end else if (vcnt == VarintLastIdx) begin
          malformed = 1'b1;   // tenth byte still wants more
        end else begin
          vcnt = vcnt + 1'b1;
        end
      end
    end
    if (last) begin
      // ending inside an element counts as malformed
      if (pm != PM_TAG || vcnt != '0) malformed = 1'b1;
      r      = '0;
      r.kind = KIND_SUMMARY;
      if (malformed || kept_pay_field == '0) begin
        r.status = 1'b1;
      end else begin
        r.version   = kept_version;
        r.req_ident = kept_req_id;
        r.pay_field = kept_pay_field;
      end
      step_results = {step_results, r};
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Message builders for the random part.
  // ---------------------------------------------------------------------------
  function automatic int rand_pad();
    return ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
  endfunction

  // Little-endian base-128, optionally padded with non-minimal bytes (ten at most).
  function automatic void put_varint(input logic [63:0] v, input int pad);
    int          len;
    int          total;
    logic [63:0] chunk;
    logic [7:0]  vb;
    len = 1;
    while (len < 10 && (v >> (7 * len)) != 0) len++;
    total = (len + pad > 10) ? 10 : len + pad;
    for (int k = 0; k < total; k++) begin
      chunk = v >> (7 * k);
      vb    = {(k < total - 1) ? 1'b1 : 1'b0, chunk[6:0]};
      msg_q = {msg_q, vb};
    end
  endfunction

  function automatic void put_tag(input logic [63:0] fld, input logic [2:0] wt);
    put_varint((fld << 3) | {61'd0, wt}, rand_pad());
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(4))
      0:       return $urandom_range(127);
      1:       return $urandom_range(16383);
      2:       return {$urandom, $urandom} >> $urandom_range(63);
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random field number, usually of a field that is skipped; huge numbers get truncated by the core.
  function automatic logic [63:0] rand_field(input logic allow_pay);
    logic [63:0] f;
    case ($urandom_range(5))
      0:       f = $urandom_range(9, 3);
      1:       f = $urandom_range(4095, 20);
      2:       f = $urandom;
      3:       f = {$urandom, $urandom} >> 3;
      4:       f = $urandom_range(19, 10);
      default: f = $urandom_range(2, 1);   // version/request id, also under another wire type
    endcase
    if (!allow_pay && (f inside {[PayFieldLo:PayFieldHi]})) f = f + 10;
    return f;
  endfunction

  function automatic void put_payload();
    int unsigned n;
    put_tag($urandom_range(19, 10), WIRE_LEN);
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
    put_varint(n, rand_pad());
    repeat (n) msg_q = {msg_q, 8'($urandom)};
  endfunction

  function automatic void put_field();
    int unsigned n;
    case ($urandom_range(5))
      0: begin
        put_tag(FieldVersion, WIRE_VARINT);
        put_varint(rand_value(), rand_pad());
      end
      1: begin
        put_tag(FieldReqId, WIRE_VARINT);
        put_varint(rand_value(), rand_pad());
      end
      2: begin
        put_tag(rand_field(1'b1), WIRE_VARINT);
        put_varint(rand_value(), rand_pad());
      end
      3: begin
        put_tag(rand_field(1'b1), WIRE_I64);
        repeat (Fixed64Bytes) msg_q = {msg_q, 8'($urandom)};
      end
      4: begin
        put_tag(rand_field(1'b1), WIRE_I32);
        repeat (Fixed32Bytes) msg_q = {msg_q, 8'($urandom)};
      end
      default: begin
        put_tag(rand_field(1'b0), WIRE_LEN);
        n = $urandom_range(6);
        put_varint(n, rand_pad());
        repeat (n) msg_q = {msg_q, 8'($urandom)};
      end
    endcase
  endfunction

  function automatic void put_fault(input fault_e fault);
    logic [63:0] len;
    case (fault)
      FLT_ZERO_TAG: put_varint('0, $urandom_range(2));
      FLT_BAD_WIRE: begin
        case ($urandom_range(3))
          0:       put_tag(rand_field(1'b1), WIRE_SGROUP);
          1:       put_tag(rand_field(1'b1), WIRE_EGROUP);
          2:       put_tag(rand_field(1'b1), WIRE_RSVD6);
          default: put_tag(rand_field(1'b1), WIRE_RSVD7);
        endcase
      end
      FLT_OVERLONG: repeat (10) msg_q = {msg_q, VarintMore | 8'($urandom_range(127))};
      FLT_SECOND_PAY: begin
        put_payload();
        put_payload();
      end
      FLT_HUGE_LEN: begin
        // exactly the limit is legal but can never complete in a short message
        case ($urandom_range(2))
          0:       len = MaxMsgBytes + 1;
          1:       len = MaxMsgBytes;
          default: len = {$urandom, $urandom} | 64'(MaxMsgBytes + 1);
        endcase
        put_tag($urandom_range(1) ? 64'($urandom_range(19, 10)) : rand_field(1'b0), WIRE_LEN);
        put_varint(len, rand_pad());
      end
      default: ;
    endcase
  endfunction

  // Mostly well-formed envelopes with random content; the rest damaged or pure noise.
  task automatic build_message();
    int     nf;
    int     pay_at;
    int     fault_at;
    int     cut;
    fault_e fault;
    msg_q.delete();
    nf       = $urandom_range(5);
    pay_at   = ($urandom_range(99) < 85) ? $urandom_range(nf) : -1;
    fault    = ($urandom_range(99) < 70) ? FLT_NONE
                                         : fault_e'($urandom_range(FLT_NOISE, FLT_ZERO_TAG));
    fault_at = $urandom_range(nf);
    for (int i = 0; i <= nf; i++) begin
      if (i == fault_at) put_fault(fault);
      if (i == pay_at) put_payload();
      if (i < nf) put_field();
    end
    if (msg_q.size() == 0) put_field();
    if (fault == FLT_TRUNCATE && msg_q.size() > 1) begin
      cut = $urandom_range(msg_q.size() - 1, 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
    if (fault == FLT_NOISE) begin
      msg_q.delete();
      repeat ($urandom_range(12, 1)) msg_q = {msg_q, 8'($urandom)};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: drives at the falling edge, holds until the transaction is taken,
  // then logs what the core now owes us.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input pep_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_if.valid     = 1'b0;
      in_if.data_byte = 8'($urandom);   // junk on the bus while idle
      in_if.last_byte = 1'($urandom);
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.last_byte = last;
    do @(posedge clk_i); while (!in_if.ready);
    parse_byte(b, last);
    if (typed) awaited_results = {awaited_results, want};
    else awaited_results = {awaited_results, step_results};
    bytes_sent++;
  endtask

  // Sender goes quiet until the core has delivered everything it owes.
  task automatic wait_all_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Result receiver: ready re-rolled every falling edge.
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: each result transaction against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    pep_result_t got;
    pep_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind         = out_if.kind;
      got.payload_byte = out_if.payload_byte;
      got.status       = out_if.status;
      got.version      = out_if.version;
      got.req_ident    = out_if.req_ident;
      got.pay_field    = out_if.pay_field;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("status", want.status, got.status);
        check_field("version", want.version, got.version);
        check_field("req_ident", want.req_ident, got.req_ident);
        check_field("pay_field", want.pay_field, got.pay_field);
      end
    end
  end

  // Watchdog: any transaction on either side counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni) quiet_cycles <= 0;
    else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Directed envelopes. Typed rows end a message the core must call malformed;
  // all other rows go through the shadow parser.
  dir_row_t dir_rows [34] = '{
    // zero tag as the whole message
    '{8'h00, 1'b1, 1'b1, BadSummary},
    // field 1 with wire type 3, then with wire type 7
    '{8'h0B, 1'b1, 1'b1, BadSummary},
    '{8'h0F, 1'b1, 1'b1, BadSummary},
    // message ends right after a tag
    '{8'h08, 1'b1, 1'b1, BadSummary},
    // field 1 as length-delimited, length one above the maximum
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h40, 1'b1, 1'b1, BadSummary},
    // tag varint still continuing on its tenth byte
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, BadSummary},
    // version twice (last wins), field 1 as an empty blob (skipped),
    // payload on field 19 whose final byte is also the message's last
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h07, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h9A, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    // empty payload on field 10 still counts, so a second one on field 11 is an error
    '{8'h52, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b1, 1'b1, BadSummary}
  };

  // Idling per phase: none, sender idle, receiver stalling, both.
  int unsigned src_idle_tbl [4] = '{0, 83, 0, 26};
  int unsigned snk_stall_tbl [4] = '{0, 0, 83, 26};

  initial begin : stimulus
    int unsigned phase_start;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    mismatches      = 0;
    bytes_sent      = 0;
    clear_parser();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_all_results();

    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct  = src_idle_tbl[phase];
      snk_stall_pct = snk_stall_tbl[phase];
      phase_start   = bytes_sent;
      while (bytes_sent - phase_start < ItemsPerPhase) begin
        build_message();
        foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
      end
      wait_all_results();   // full drain between phases
    end

    // anything extra the core emits now shows up as an unexpected result
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### protobuf_envelope_parser_core.f
+incdir+src
src/pep_pkg.sv
src/pep_if.sv
src/pep_parser.sv
src/pep_result_fifo.sv
src/protobuf_envelope_parser_core.sv
verif/testbench.sv
